### rtl/ray_triangle_intersect_unit_assert.svh
// Assertion macros shared by the ray-triangle intersection RTL.
`ifndef RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_INTERSECT_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define RTI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RTI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/rti_pkg.sv
// Types and constants for the ray-triangle intersection unit.
package rti_pkg;

  localparam int CW    = 32;
  localparam int EW    = 33;
  localparam int PW    = 66;
  localparam int QCW   = 67;
  localparam int DW    = 104;
  localparam int QW    = 31;
  localparam int BW    = 17;
  localparam int DISTW = 31;
  localparam int AW    = 5;

  localparam logic [CW-1:0]    DIR_Z_RESET = 32'h0001_0000;
  localparam logic [DISTW-1:0] DIST_MAX    = '1;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5
  } reg_idx_t;

  typedef logic [2:0][EW-1:0] vec_e_t;

  typedef struct packed {
    logic signed [CW-1:0] a_x;
    logic signed [CW-1:0] a_y;
    logic signed [CW-1:0] a_z;
    logic signed [CW-1:0] b_x;
    logic signed [CW-1:0] b_y;
    logic signed [CW-1:0] b_z;
    logic signed [CW-1:0] c_x;
    logic signed [CW-1:0] c_y;
    logic signed [CW-1:0] c_z;
  } in_item_t;

  typedef struct packed {
    logic             is_hit;
    logic [DISTW-1:0] distance;
    logic [BW-1:0]    bary_u;
    logic [BW-1:0]    bary_v;
    logic [BW-1:0]    bary_w;
  } out_item_t;

  typedef struct packed {
    logic [2:0][CW-1:0] org;
    logic [2:0][CW-1:0] dir;
  } ray_t;

  typedef struct packed {
    vec_e_t              e1;
    vec_e_t              e2;
    vec_e_t              s;
    logic [2:0][PW-1:0]  p;
    logic [2:0][QCW-1:0] q;
  } geom_t;

  typedef struct packed {
    logic [DW-1:0] det;
    logic [DW-1:0] nu;
    logic [DW-1:0] nv;
    logic [DW-1:0] nt;
  } dot_t;

  typedef struct packed {
    logic miss;
    logic sat;
  } flags_t;

endpackage

### rtl/rti_geom.sv
// Edge vectors and cross products p = dir x e2, q = s x e1 (three stages).
module rti_geom (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  rti_pkg::in_item_t item,
  input  rti_pkg::ray_t     ray,
  output logic              geom_vld,
  output rti_pkg::geom_t    geom
);

  localparam int EW  = rti_pkg::EW;
  localparam int PW  = rti_pkg::PW;
  localparam int QCW = rti_pkg::QCW;

  logic [2:0][rti_pkg::CW-1:0] va, vb, vc;
  rti_pkg::vec_e_t e1_nxt, e2_nxt, s_nxt;
  rti_pkg::vec_e_t e1_r, e2_r, s_r;
  rti_pkg::vec_e_t e1_2r, e2_2r, s_2r;
  logic v1_r, v2_r, v3_r;

  logic signed [PW-2:0]  pm_nxt [6];
  logic signed [PW-2:0]  pm_r   [6];
  logic signed [QCW-2:0] qm_nxt [6];
  logic signed [QCW-2:0] qm_r   [6];

  rti_pkg::geom_t geom_nxt, geom_r;

  // stage 1: edges and origin offset
  always_comb begin
    va = {item.a_z, item.a_y, item.a_x};
    vb = {item.b_z, item.b_y, item.b_x};
    vc = {item.c_z, item.c_y, item.c_x};
    for (int i = 0; i < 3; i++) begin
      e1_nxt[i] = EW'($signed(vb[i])) - EW'($signed(va[i]));
      e2_nxt[i] = EW'($signed(vc[i])) - EW'($signed(va[i]));
      s_nxt[i]  = EW'($signed(ray.org[i])) - EW'($signed(va[i]));
    end
  end

  // stage 2: cross product terms
  always_comb begin
    pm_nxt[0] = $signed(ray.dir[1]) * $signed(e2_r[2]);
    pm_nxt[1] = $signed(ray.dir[2]) * $signed(e2_r[1]);
    pm_nxt[2] = $signed(ray.dir[2]) * $signed(e2_r[0]);
    pm_nxt[3] = $signed(ray.dir[0]) * $signed(e2_r[2]);
    pm_nxt[4] = $signed(ray.dir[0]) * $signed(e2_r[1]);
    pm_nxt[5] = $signed(ray.dir[1]) * $signed(e2_r[0]);
    qm_nxt[0] = $signed(s_r[1]) * $signed(e1_r[2]);
    qm_nxt[1] = $signed(s_r[2]) * $signed(e1_r[1]);
    qm_nxt[2] = $signed(s_r[2]) * $signed(e1_r[0]);
    qm_nxt[3] = $signed(s_r[0]) * $signed(e1_r[2]);
    qm_nxt[4] = $signed(s_r[0]) * $signed(e1_r[1]);
    qm_nxt[5] = $signed(s_r[1]) * $signed(e1_r[0]);
  end

  // stage 3: differences
  always_comb begin
    geom_nxt.e1 = e1_2r;
    geom_nxt.e2 = e2_2r;
    geom_nxt.s  = s_2r;
    for (int i = 0; i < 3; i++) begin
      geom_nxt.p[i] = PW'(pm_r[2*i]) - PW'(pm_r[2*i+1]);
      geom_nxt.q[i] = QCW'(qm_r[2*i]) - QCW'(qm_r[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_r   <= e1_nxt;
      e2_r   <= e2_nxt;
      s_r    <= s_nxt;
      e1_2r  <= e1_r;
      e2_2r  <= e2_r;
      s_2r   <= s_r;
      pm_r   <= pm_nxt;
      qm_r   <= qm_nxt;
      geom_r <= geom_nxt;
    end
  end

  assign geom_vld = v3_r;
  assign geom     = geom_r;

endmodule

### rtl/rti_dot.sv
// Dot products, sign fold and hit tests (five stages).
module rti_dot #(
  parameter int FRAC_BITS = 16,
  parameter int EPS       = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             geom_vld,
  input  rti_pkg::geom_t   geom,
  input  rti_pkg::ray_t    ray,
  output logic             dot_vld,
  output rti_pkg::dot_t    dot,
  output rti_pkg::flags_t  flags
);

  localparam int EW  = rti_pkg::EW;
  localparam int QCW = rti_pkg::QCW;
  localparam int DW  = rti_pkg::DW;
  localparam int QW  = rti_pkg::QW;
  localparam int LOW = 32;
  localparam int PLW = EW + LOW + 1;
  localparam int PHW = QCW - LOW + EW;
  localparam logic [DW-1:0] THR = DW'(EPS) << (2 * FRAC_BITS);

  logic [EW-1:0]  na [4][3];
  logic [QCW-1:0] wd [4][3];

  logic signed [PLW-1:0] pl_nxt [4][3];
  logic signed [PLW-1:0] pl_r   [4][3];
  logic signed [PHW-1:0] ph_nxt [4][3];
  logic signed [PHW-1:0] ph_r   [4][3];
  logic signed [DW-1:0]  term_nxt [4][3];
  logic signed [DW-1:0]  term_r   [4][3];
  logic signed [DW-1:0]  sum_nxt [4];
  logic signed [DW-1:0]  sum_r   [4];
  logic [DW-1:0]         abs_nxt [4];
  logic [DW-1:0]         abs_r   [4];

  logic [4:0] vld_r;

  logic [DW:0]    uv_sum;
  logic [DW+31:0] nt_sh, det_sh;
  rti_pkg::dot_t   dot_nxt, dot_r;
  rti_pkg::flags_t flags_nxt, flags_r;

  // stage 4: partial products, wide operand split at bit 32
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      na[0][i] = geom.e1[i];
      na[1][i] = geom.s[i];
      na[2][i] = EW'($signed(ray.dir[i]));
      na[3][i] = geom.e2[i];
      wd[0][i] = QCW'($signed(geom.p[i]));
      wd[1][i] = QCW'($signed(geom.p[i]));
      wd[2][i] = geom.q[i];
      wd[3][i] = geom.q[i];
    end
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        pl_nxt[k][i] = $signed({1'b0, wd[k][i][LOW-1:0]}) * $signed(na[k][i]);
        ph_nxt[k][i] = $signed(wd[k][i][QCW-1:LOW]) * $signed(na[k][i]);
      end
    end
  end

  // stage 5: recombine halves
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        term_nxt[k][i] = (DW'(ph_r[k][i]) <<< LOW) + DW'(pl_r[k][i]);
      end
    end
  end

  // stage 6: three-term sums; stage 7: fold sign of det
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_nxt[k] = term_r[k][0] + term_r[k][1] + term_r[k][2];
      abs_nxt[k] = sum_r[0][DW-1] ? DW'(-sum_r[k]) : DW'(sum_r[k]);
    end
  end

  // stage 8: range tests and t saturation
  always_comb begin
    dot_nxt.det = abs_r[0];
    dot_nxt.nu  = abs_r[1];
    dot_nxt.nv  = abs_r[2];
    dot_nxt.nt  = abs_r[3];
    uv_sum = {1'b0, abs_r[1]} + {1'b0, abs_r[2]};
    nt_sh  = (DW+32)'(abs_r[3]) << FRAC_BITS;
    det_sh = (DW+32)'(abs_r[0]) << QW;
    flags_nxt.miss = (abs_r[0] < THR)
                  || abs_r[1][DW-1] || (abs_r[1] > abs_r[0])
                  || abs_r[2][DW-1] || (uv_sum > {1'b0, abs_r[0]})
                  || abs_r[3][DW-1];
    flags_nxt.sat  = nt_sh >= det_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], geom_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl_r    <= pl_nxt;
      ph_r    <= ph_nxt;
      term_r  <= term_nxt;
      sum_r   <= sum_nxt;
      abs_r   <= abs_nxt;
      dot_r   <= dot_nxt;
      flags_r <= flags_nxt;
    end
  end

  assign dot_vld = vld_r[4];
  assign dot     = dot_r;
  assign flags   = flags_r;

endmodule

### rtl/rti_div.sv
// Pipelined restoring divider: t, u, v lanes share det, one quotient bit per stage.
module rti_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       dot_vld,
  input  rti_pkg::dot_t              dot,
  input  rti_pkg::flags_t            flags,
  output logic                       div_vld,
  output rti_pkg::flags_t            div_flags,
  output logic [rti_pkg::QW-1:0]     tq,
  output logic [rti_pkg::QW-1:0]     uq,
  output logic [rti_pkg::QW-1:0]     vq
);

  localparam int DW = rti_pkg::DW;
  localparam int QW = rti_pkg::QW;
  localparam int RW = DW + 1;
  localparam int NW = DW + FRAC_BITS;

  logic [DW-1:0] num [3];
  logic [NW-1:0] nsh [3];
  logic [RW-1:0] rem_init [3];
  logic [QW-1:0] low_init [3];

  logic [RW-1:0] rem_nxt [QW][3];
  logic [RW-1:0] rem_r   [QW][3];
  logic [QW-1:0] low_nxt [QW][3];
  logic [QW-1:0] low_r   [QW][3];
  logic [QW-1:0] quo_nxt [QW][3];
  logic [QW-1:0] quo_r   [QW][3];
  logic [DW-1:0] den_r   [QW];
  rti_pkg::flags_t flg_r [QW];
  logic [QW-1:0] vld_r;

  always_comb begin
    num[0] = dot.nt;
    num[1] = dot.nu;
    num[2] = dot.nv;
    for (int l = 0; l < 3; l++) begin
      nsh[l]      = NW'(num[l]) << FRAC_BITS;
      rem_init[l] = RW'(nsh[l] >> QW);
      low_init[l] = nsh[l][QW-1:0];
    end
  end

  always_comb begin
    logic [RW-1:0] rin;
    logic [QW-1:0] lin;
    logic [QW-1:0] qin;
    logic [DW-1:0] din;
    logic [RW-1:0] r2;
    logic [RW:0]   diff;
    for (int j = 0; j < QW; j++) begin
      for (int l = 0; l < 3; l++) begin
        if (j == 0) begin
          rin = rem_init[l];
          lin = low_init[l];
          qin = '0;
          din = dot.det;
        end else begin
          rin = rem_r[j-1][l];
          lin = low_r[j-1][l];
          qin = quo_r[j-1][l];
          din = den_r[j-1];
        end
        r2   = {rin[RW-2:0], lin[QW-1-j]};
        diff = {1'b0, r2} - (RW+1)'(din);
        rem_nxt[j][l] = diff[RW] ? r2 : diff[RW-1:0];
        low_nxt[j][l] = lin;
        quo_nxt[j][l] = {qin[QW-2:0], ~diff[RW]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], dot_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r    <= rem_nxt;
      low_r    <= low_nxt;
      quo_r    <= quo_nxt;
      den_r[0] <= dot.det;
      flg_r[0] <= flags;
      for (int j = 1; j < QW; j++) begin
        den_r[j] <= den_r[j-1];
        flg_r[j] <= flg_r[j-1];
      end
    end
  end

  assign div_vld   = vld_r[QW-1];
  assign div_flags = flg_r[QW-1];
  assign tq        = quo_r[QW-1][0];
  assign uq        = quo_r[QW-1][1];
  assign vq        = quo_r[QW-1][2];

endmodule

### rtl/ray_triangle_intersect_unit.sv
// Top level of the ray-triangle intersection unit: registers, pipeline, output stage.
//
// Software writes the ray origin and direction (signed Q16.16) over the APB
// port at byte addresses 0..20; reads return the written values. Each item on
// the in_ channel is one triangle (three vertices). Exactly one item leaves on
// the out_ channel per triangle, in order: is_hit, distance t (saturated),
// and barycentrics u, v, w; a miss gives all-zero fields.
// The pipeline runs edges and cross products, then dot products and tests, then
// the divider (one quotient bit per stage), then one output register.
// Throughput: one triangle per cycle unless stalled; the 31-stage divider sets depth.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears the pipeline valid bits and loads origin 0 and direction +z.
// Register writes are meant for times when no triangle is in flight.
module ray_triangle_intersect_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rti_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rti_pkg::out_item_t          out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rti_pkg::AW-1:0]      paddr,
  input  logic [rti_pkg::CW-1:0]      pwdata,
  output logic [rti_pkg::CW-1:0]      prdata,
  output logic                        pready
);

`include "ray_triangle_intersect_unit_assert.svh"

  localparam int QW    = rti_pkg::QW;
  localparam int BW    = rti_pkg::BW;
  localparam int DISTW = rti_pkg::DISTW;
  localparam int EPS_RAW = ((1 << FRAC_BITS) + 50000) / 100000;
  localparam int EPS     = (EPS_RAW == 0) ? 1 : EPS_RAW;
  localparam logic [QW:0] ONE_Q = (QW+1)'(1) << FRAC_BITS;

  rti_pkg::ray_t     ray_r;
  rti_pkg::reg_idx_t idx;
  logic              wr;
  logic              en;

  logic            geom_vld;
  rti_pkg::geom_t  geom;
  logic            dot_vld;
  rti_pkg::dot_t   dot;
  rti_pkg::flags_t flags;
  logic            div_vld;
  rti_pkg::flags_t div_flags;
  logic [QW-1:0]   tq, uq, vq;

  logic [DISTW-1:0]   t_sat;
  logic               hit;
  logic [QW:0]        w_full;
  rti_pkg::out_item_t out_nxt, out_r;
  logic               out_valid_r;

  logic miss_fields_zero;
  logic bary_sum_ok;

  // configuration port
  assign pready = 1'b1;
  assign idx    = rti_pkg::reg_idx_t'(paddr[rti_pkg::AW-1:2]);
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ray_r.org    <= '0;
      ray_r.dir[0] <= '0;
      ray_r.dir[1] <= '0;
      ray_r.dir[2] <= rti_pkg::DIR_Z_RESET;
    end else if (wr) begin
      unique case (idx)
        rti_pkg::REG_ORG_X: ray_r.org[0] <= pwdata;
        rti_pkg::REG_ORG_Y: ray_r.org[1] <= pwdata;
        rti_pkg::REG_ORG_Z: ray_r.org[2] <= pwdata;
        rti_pkg::REG_DIR_X: ray_r.dir[0] <= pwdata;
        rti_pkg::REG_DIR_Y: ray_r.dir[1] <= pwdata;
        rti_pkg::REG_DIR_Z: ray_r.dir[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rti_pkg::REG_ORG_X: prdata = ray_r.org[0];
      rti_pkg::REG_ORG_Y: prdata = ray_r.org[1];
      rti_pkg::REG_ORG_Z: prdata = ray_r.org[2];
      rti_pkg::REG_DIR_X: prdata = ray_r.dir[0];
      rti_pkg::REG_DIR_Y: prdata = ray_r.dir[1];
      rti_pkg::REG_DIR_Z: prdata = ray_r.dir[2];
      default:            prdata = '0;
    endcase
  end

  // global advance: hold everything while a result waits under stall
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  rti_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .item     (in_data),
    .ray      (ray_r),
    .geom_vld (geom_vld),
    .geom     (geom)
  );

  rti_dot #(
    .FRAC_BITS (FRAC_BITS),
    .EPS       (EPS)
  ) u_dot (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .geom_vld (geom_vld),
    .geom     (geom),
    .ray      (ray_r),
    .dot_vld  (dot_vld),
    .dot      (dot),
    .flags    (flags)
  );

  rti_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .dot_vld   (dot_vld),
    .dot       (dot),
    .flags     (flags),
    .div_vld   (div_vld),
    .div_flags (div_flags),
    .tq        (tq),
    .uq        (uq),
    .vq        (vq)
  );

  // output stage
  always_comb begin
    t_sat  = div_flags.sat ? rti_pkg::DIST_MAX : tq;
    hit    = !div_flags.miss && (t_sat > DISTW'(EPS));
    w_full = ONE_Q - (QW+1)'(uq) - (QW+1)'(vq);
    out_nxt.is_hit   = hit;
    out_nxt.distance = hit ? t_sat : '0;
    out_nxt.bary_u   = hit ? uq[BW-1:0] : '0;
    out_nxt.bary_v   = hit ? vq[BW-1:0] : '0;
    out_nxt.bary_w   = hit ? w_full[BW-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign miss_fields_zero = (out_data.distance == '0) && (out_data.bary_u == '0)
                         && (out_data.bary_v == '0) && (out_data.bary_w == '0);
  assign bary_sum_ok = (out_data.bary_u + out_data.bary_v + out_data.bary_w)
                    == ONE_Q[BW-1:0];

  `RTI_ASSERT_IMP(a_miss_zero, out_valid && !out_data.is_hit, miss_fields_zero, "miss with data")
  `RTI_ASSERT_IMP(a_bary_sum, out_valid && out_data.is_hit, bary_sum_ok, "u+v+w not one")
  `RTI_ASSERT_IMP(a_hit_dist, out_valid && out_data.is_hit, out_data.distance > DISTW'(EPS), "t low")
  `RTI_ASSERT_NXT(a_stall_hold, out_valid && out_stall, out_valid, "result dropped")

endmodule
